// ===== hdl/packet_pool_and_queue_manager_unit_macros.svh =====
// assertion macros for the packet pool and queue manager
`ifndef PACKET_POOL_AND_QUEUE_MANAGER_UNIT_MACROS_SVH
`define PACKET_POOL_AND_QUEUE_MANAGER_UNIT_MACROS_SVH

// condition holds at every clock edge out of reset
`define PPQM_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define PPQM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define PPQM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ppqm_pkg.sv =====
// shared constants and codes for the packet pool and queue manager
package ppqm_pkg;

   localparam int POOL_SLOTS  = 16;
   localparam int QUEUE_DEPTH = 16;

   // fixed field widths
   localparam int OPCODE_W = 3;
   localparam int IDX_W    = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;
   localparam int POLICY_W = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_POLICY    = 1'd1;

   // reset values
   localparam logic [CAP_W-1:0]    CAPACITY_RESET = 5'd16;
   localparam logic [POLICY_W-1:0] POLICY_RESET   = 2'd0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC = 3'd0,
      OP_FREE  = 3'd1,
      OP_PUSH  = 3'd2,
      OP_PEEK  = 3'd3,
      OP_POP   = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_NO_FREE   = 3'd3,
      ST_FREE_FULL = 3'd4
   } status_type;

   typedef enum logic [POLICY_W-1:0] {
      POL_ERROR      = 2'd0,
      POL_DROP_OLD   = 2'd1,
      POL_DROP_NEW   = 2'd2,
      POL_ERROR_ALT  = 2'd3
   } policy_type;

endpackage

// ===== hdl/packet_pool_and_queue_manager_unit.sv =====
// Packet pool and queue manager: LIFO free list of slots plus a ring queue of slots.
// A request is taken in S_IDLE, where both memories are read, and runs in S_EXEC, where
// its response is registered once the output is free; after a capacity change leaves the
// head or count too far out for one subtraction, push and pop first run the ring index
// through a 6-step modulo unit in S_MOD. No new request is taken until the last commits.
// Reset (synchronous): free list full, queue empty, capacity 16, drop policy 0.
`include "packet_pool_and_queue_manager_unit_macros.svh"

module packet_pool_and_queue_manager_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ppqm_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [ppqm_pkg::IDX_W-1:0]           req_slot_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ppqm_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ppqm_pkg::IDX_W-1:0]           rsp_result_index,
   output logic                                 rsp_dropped_valid,
   output logic [ppqm_pkg::IDX_W-1:0]           rsp_dropped_index,
   output logic [ppqm_pkg::COUNT_W-1:0]         rsp_free_slots,
   output logic [ppqm_pkg::COUNT_W-1:0]         rsp_queue_count,
   input  logic                                 csr_wr_en,
   input  logic [ppqm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppqm_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int PADDR_W = $clog2(ppqm_pkg::POOL_SLOTS);
   localparam int QPTR_W  = (ppqm_pkg::QUEUE_DEPTH > 1) ? $clog2(ppqm_pkg::QUEUE_DEPTH) : 1;
   localparam int FCNT_W  = $clog2(ppqm_pkg::POOL_SLOTS + 1);
   localparam int QCNT_W  = $clog2(ppqm_pkg::QUEUE_DEPTH + 1);
   localparam int SUM_W   = QCNT_W + 1;
   localparam int DIV_W   = SUM_W + QCNT_W;
   localparam int STEP_W  = $clog2(SUM_W);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_MOD
   } state_type;

   state_type                           state_ff;
   logic [FCNT_W-1:0]                   free_count_ff;
   logic [QPTR_W-1:0]                   queue_head_ff;
   logic [QCNT_W-1:0]                   queue_len_ff;
   logic [ppqm_pkg::CAP_W-1:0]          capacity_ff;
   logic [ppqm_pkg::POLICY_W-1:0]       policy_ff;
   logic [ppqm_pkg::OPCODE_W-1:0]       op_ff;
   logic [ppqm_pkg::IDX_W-1:0]          slot_ff;
   logic                                mod_ready_ff;
   logic [SUM_W-1:0]                    mod_a_ff;
   logic [SUM_W-1:0]                    mod_b_ff;
   logic [STEP_W-1:0]                   mod_step_ff;

   logic                                rsp_valid_ff;
   logic [ppqm_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [ppqm_pkg::IDX_W-1:0]          rsp_result_ff;
   logic                                rsp_dropped_valid_ff;
   logic [ppqm_pkg::IDX_W-1:0]          rsp_dropped_index_ff;
   logic [ppqm_pkg::COUNT_W-1:0]        rsp_free_slots_ff;
   logic [ppqm_pkg::COUNT_W-1:0]        rsp_queue_count_ff;

   // memories and their registered read ports
   logic [ppqm_pkg::IDX_W-1:0]          stack_mem [ppqm_pkg::POOL_SLOTS];
   logic [ppqm_pkg::POOL_SLOTS-1:0]     stack_written_ff;
   logic [ppqm_pkg::IDX_W-1:0]          stack_rd_ff;
   logic                                stack_rd_written_ff;
   logic [PADDR_W-1:0]                  stack_raddr_ff;
   logic [ppqm_pkg::IDX_W-1:0]          ring_mem [ppqm_pkg::QUEUE_DEPTH];
   logic [ppqm_pkg::IDX_W-1:0]          ring_rd_ff;

   logic                                req_accept;
   logic                                out_free;
   logic [QCNT_W-1:0]                   eff_cap;
   logic [SUM_W-1:0]                    twice_cap;
   logic [SUM_W-1:0]                    cap_ext;
   logic [SUM_W-1:0]                    sum_a;
   logic [SUM_W-1:0]                    sum_b;
   logic [SUM_W-1:0]                    fast_a;
   logic [SUM_W-1:0]                    fast_b;
   logic [QPTR_W-1:0]                   head_mod;
   logic [QPTR_W-1:0]                   tail_mod;
   logic [DIV_W-1:0]                    div_shift;
   logic [PADDR_W-1:0]                  stack_raddr;
   logic [ppqm_pkg::IDX_W-1:0]          stack_top;
   logic                                free_full;
   logic                                queue_full;
   logic                                uses_mod;
   logic                                need_slow;
   logic                                commit;

   logic [ppqm_pkg::STATUS_W-1:0]       status_in;
   logic [ppqm_pkg::IDX_W-1:0]          result_in;
   logic                                dropped_valid_in;
   logic [ppqm_pkg::IDX_W-1:0]          dropped_index_in;
   logic [FCNT_W-1:0]                   free_count_in;
   logic [QCNT_W-1:0]                   queue_len_in;
   logic [QPTR_W-1:0]                   queue_head_in;
   logic                                stack_wr;
   logic [ppqm_pkg::IDX_W-1:0]          stack_wdata;
   logic                                ring_wr;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_index  = rsp_result_ff;
   assign rsp_dropped_valid = rsp_dropped_valid_ff;
   assign rsp_dropped_index = rsp_dropped_index_ff;
   assign rsp_free_slots    = rsp_free_slots_ff;
   assign rsp_queue_count   = rsp_queue_count_ff;

   // capacity of 0 acts as 1, anything above the ring depth as the depth
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = QCNT_W'(1);
      end else if (capacity_ff > ppqm_pkg::CAP_W'(ppqm_pkg::QUEUE_DEPTH)) begin
         eff_cap = QCNT_W'(ppqm_pkg::QUEUE_DEPTH);
      end else begin
         eff_cap = QCNT_W'(capacity_ff);
      end
   end

   assign cap_ext   = SUM_W'(eff_cap);
   assign twice_cap = {eff_cap, 1'b0};
   assign sum_a     = SUM_W'(queue_head_ff) + SUM_W'(1);
   assign sum_b     = SUM_W'(queue_head_ff) + SUM_W'(queue_len_ff);
   assign fast_a    = (sum_a >= cap_ext) ? sum_a - cap_ext : sum_a;
   assign fast_b    = (sum_b >= cap_ext) ? sum_b - cap_ext : sum_b;
   assign head_mod  = mod_ready_ff ? QPTR_W'(mod_a_ff) : QPTR_W'(fast_a);
   assign tail_mod  = mod_ready_ff ? QPTR_W'(mod_b_ff) : QPTR_W'(fast_b);
   assign div_shift = DIV_W'(eff_cap) << mod_step_ff;

   assign stack_raddr = PADDR_W'(free_count_ff - FCNT_W'(1));
   // an entry never written reads as its own address, the free list's reset value
   assign stack_top   = stack_rd_written_ff ? stack_rd_ff : ppqm_pkg::IDX_W'(stack_raddr_ff);
   assign free_full   = (free_count_ff >= FCNT_W'(ppqm_pkg::POOL_SLOTS));
   assign queue_full  = (queue_len_ff >= eff_cap);

   assign uses_mod  = (op_ff == ppqm_pkg::OP_PUSH) || (op_ff == ppqm_pkg::OP_POP);
   // one compare-subtract is enough unless a capacity change left the indices far out
   assign need_slow = uses_mod && !mod_ready_ff &&
                      !((sum_a < twice_cap) && (sum_b < twice_cap));
   assign commit    = (state_ff == S_EXEC) && !need_slow && out_free;

   always_comb begin
      status_in        = ppqm_pkg::ST_OK;
      result_in        = '0;
      dropped_valid_in = 1'b0;
      dropped_index_in = '0;
      free_count_in    = free_count_ff;
      queue_len_in     = queue_len_ff;
      queue_head_in    = queue_head_ff;
      stack_wr         = 1'b0;
      stack_wdata      = slot_ff;
      ring_wr          = 1'b0;
      case (op_ff)
         ppqm_pkg::OP_ALLOC: begin
            if (free_count_ff == '0) begin
               status_in = ppqm_pkg::ST_NO_FREE;
            end else begin
               free_count_in = free_count_ff - FCNT_W'(1);
               result_in     = stack_top;
            end
         end
         ppqm_pkg::OP_FREE: begin
            if (free_full) begin
               status_in = ppqm_pkg::ST_FREE_FULL;
            end else begin
               stack_wr      = 1'b1;
               free_count_in = free_count_ff + FCNT_W'(1);
            end
         end
         ppqm_pkg::OP_PUSH: begin
            if (!queue_full) begin
               ring_wr      = 1'b1;
               queue_len_in = queue_len_ff + QCNT_W'(1);
            end else if (policy_ff == ppqm_pkg::POL_DROP_OLD) begin
               if (free_full) begin
                  status_in = ppqm_pkg::ST_FREE_FULL;
               end else begin
                  // oldest goes back to the free list, pushed slot lands at the tail
                  stack_wr         = 1'b1;
                  stack_wdata      = ring_rd_ff;
                  free_count_in    = free_count_ff + FCNT_W'(1);
                  ring_wr          = 1'b1;
                  queue_head_in    = (queue_len_ff == QCNT_W'(1)) ? '0 : head_mod;
                  dropped_valid_in = 1'b1;
                  dropped_index_in = ring_rd_ff;
               end
            end else if (policy_ff == ppqm_pkg::POL_DROP_NEW) begin
               if (free_full) begin
                  status_in = ppqm_pkg::ST_FREE_FULL;
               end else begin
                  stack_wr         = 1'b1;
                  free_count_in    = free_count_ff + FCNT_W'(1);
                  dropped_valid_in = 1'b1;
                  dropped_index_in = slot_ff;
               end
            end else begin
               status_in = ppqm_pkg::ST_OVERFLOW;
            end
         end
         ppqm_pkg::OP_PEEK: begin
            if (queue_len_ff == '0) begin
               status_in = ppqm_pkg::ST_EMPTY;
            end else begin
               result_in = ring_rd_ff;
            end
         end
         ppqm_pkg::OP_POP: begin
            if (queue_len_ff == '0) begin
               status_in = ppqm_pkg::ST_EMPTY;
            end else begin
               result_in     = ring_rd_ff;
               queue_len_in  = queue_len_ff - QCNT_W'(1);
               queue_head_in = (queue_len_ff == QCNT_W'(1)) ? '0 : head_mod;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer, counters, configuration and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= FCNT_W'(ppqm_pkg::POOL_SLOTS);
         queue_head_ff <= '0;
         queue_len_ff  <= '0;
         capacity_ff   <= ppqm_pkg::CAPACITY_RESET;
         policy_ff     <= ppqm_pkg::POLICY_RESET;
         mod_ready_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ppqm_pkg::CSR_QUEUE_CAPACITY: capacity_ff <= ppqm_pkg::CAP_W'(csr_wr_data);
               ppqm_pkg::CSR_DROP_POLICY:    policy_ff <= ppqm_pkg::POLICY_W'(csr_wr_data);
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  op_ff    <= req_opcode;
                  slot_ff  <= req_slot_index;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (need_slow) begin
                  mod_a_ff    <= sum_a;
                  mod_b_ff    <= sum_b;
                  mod_step_ff <= STEP_W'(SUM_W - 1);
                  state_ff    <= S_MOD;
               end else if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_status_ff        <= status_in;
                  rsp_result_ff        <= result_in;
                  rsp_dropped_valid_ff <= dropped_valid_in;
                  rsp_dropped_index_ff <= dropped_index_in;
                  rsp_free_slots_ff    <= ppqm_pkg::COUNT_W'(free_count_in);
                  rsp_queue_count_ff   <= ppqm_pkg::COUNT_W'(queue_len_in);
                  free_count_ff        <= free_count_in;
                  queue_len_ff         <= queue_len_in;
                  queue_head_ff        <= queue_head_in;
                  mod_ready_ff         <= 1'b0;
                  state_ff             <= S_IDLE;
               end
            end
            S_MOD: begin
               // restoring remainder, one shifted capacity per cycle on both operands
               if (DIV_W'(mod_a_ff) >= div_shift) begin
                  mod_a_ff <= SUM_W'(DIV_W'(mod_a_ff) - div_shift);
               end
               if (DIV_W'(mod_b_ff) >= div_shift) begin
                  mod_b_ff <= SUM_W'(DIV_W'(mod_b_ff) - div_shift);
               end
               if (mod_step_ff == '0) begin
                  mod_ready_ff <= 1'b1;
                  state_ff     <= S_EXEC;
               end else begin
                  mod_step_ff <= mod_step_ff - STEP_W'(1);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // reads happen only on request accept and writes only on commit, so they never collide
   always_ff @(posedge clock) begin
      if (commit && stack_wr) begin
         stack_mem[PADDR_W'(free_count_ff)] <= stack_wdata;
      end
      if (req_accept) begin
         stack_rd_ff    <= stack_mem[stack_raddr];
         stack_raddr_ff <= stack_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_written_ff    <= '0;
         stack_rd_written_ff <= 1'b0;
      end else begin
         if (commit && stack_wr) begin
            stack_written_ff[PADDR_W'(free_count_ff)] <= 1'b1;
         end
         if (req_accept) begin
            stack_rd_written_ff <= stack_written_ff[stack_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit && ring_wr) begin
         ring_mem[tail_mod] <= slot_ff;
      end
      if (req_accept) begin
         ring_rd_ff <= ring_mem[queue_head_ff];
      end
   end

   `PPQM_ASSERT_ALWAYS(a_free_count_bound, free_count_ff <= FCNT_W'(ppqm_pkg::POOL_SLOTS), "free count beyond pool size")
   `PPQM_ASSERT_ALWAYS(a_queue_len_bound, queue_len_ff <= QCNT_W'(ppqm_pkg::QUEUE_DEPTH), "queue length beyond ring depth")
   `PPQM_ASSERT_NEXT(a_accept_starts_exec, req_accept, state_ff == S_EXEC, "accepted request did not start execution")
   `PPQM_ASSERT_IMP(a_mod_not_ready_in_iter, state_ff == S_MOD, !mod_ready_ff, "modulo result flagged ready mid iteration")
   `PPQM_ASSERT_IMP(a_empty_means_zero, rsp_valid_ff && (rsp_status_ff == ppqm_pkg::ST_EMPTY), rsp_queue_count_ff == '0, "empty status with queued entries")

endmodule

// ===== tb/tb_packet_pool_and_queue_manager_unit.sv =====
// self-checking testbench for the packet pool and queue manager with a local model
module tb_packet_pool_and_queue_manager_unit;

   localparam int TIMEOUT_UNITS = 2_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int PRINT_LIMIT   = 30;

   localparam int POOL_SLOTS  = ppqm_pkg::POOL_SLOTS;
   localparam int QUEUE_DEPTH = ppqm_pkg::QUEUE_DEPTH;
   localparam int OPCODE_W    = ppqm_pkg::OPCODE_W;
   localparam int IDX_W       = ppqm_pkg::IDX_W;
   localparam int STATUS_W    = ppqm_pkg::STATUS_W;
   localparam int COUNT_W     = ppqm_pkg::COUNT_W;
   localparam int CAP_W       = ppqm_pkg::CAP_W;
   localparam int POLICY_W    = ppqm_pkg::POLICY_W;
   localparam int CSR_IDX_W   = ppqm_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = ppqm_pkg::CSR_DATA_W;

   typedef struct {
      ppqm_pkg::status_type   status;
      logic [IDX_W-1:0]       result_index;
      logic                   dropped_valid;
      logic [IDX_W-1:0]       dropped_index;
      logic [COUNT_W-1:0]     free_slots;
      logic [COUNT_W-1:0]     queue_count;
   } pool_reply_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [OPCODE_W-1:0]    req_opcode;
   logic [IDX_W-1:0]       req_slot_index;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [IDX_W-1:0]       rsp_result_index;
   logic                   rsp_dropped_valid;
   logic [IDX_W-1:0]       rsp_dropped_index;
   logic [COUNT_W-1:0]     rsp_free_slots;
   logic [COUNT_W-1:0]     rsp_queue_count;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   // model of the slot pool and queue
   logic [IDX_W-1:0]  pool_stack [POOL_SLOTS];
   int unsigned       pool_depth;
   logic [IDX_W-1:0]  ring_slots [QUEUE_DEPTH];
   bit                ring_filled [QUEUE_DEPTH];
   int unsigned       ring_head;
   int unsigned       ring_len;
   logic [CAP_W-1:0]  capacity_reg;
   logic [POLICY_W-1:0] policy_reg;

   pool_reply_type reply_queue [$];
   pool_reply_type last_reply;

   int error_count = 0;
   int requests_sent = 0;
   int replies_checked = 0;
   int register_writes = 0;
   int holds_done = 0;
   int dropping_pushes = 0;
   int status_tally [5] = '{default: 0};
   int idle_percent = 30;
   bit hold_pending = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   packet_pool_and_queue_manager_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_slot_index    (req_slot_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_index  (rsp_result_index),
      .rsp_dropped_valid (rsp_dropped_valid),
      .rsp_dropped_index (rsp_dropped_index),
      .rsp_free_slots    (rsp_free_slots),
      .rsp_queue_count   (rsp_queue_count),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 10);
      else return $urandom_range(11, 40);
   endfunction

   function automatic void reset_model();
      for (int i = 0; i < POOL_SLOTS; i++) pool_stack[i] = IDX_W'(i);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ring_slots[i] = '0;
         ring_filled[i] = 1'b0;
      end
      pool_depth = POOL_SLOTS;
      ring_head = 0;
      ring_len = 0;
      capacity_reg = ppqm_pkg::CAPACITY_RESET;
      policy_reg = ppqm_pkg::POLICY_RESET;
   endfunction

   // zero acts as one, anything above the depth as the depth
   function automatic int unsigned live_capacity();
      int unsigned c;
      c = 32'(capacity_reg);
      if (c == 0) c = 1;
      if (c > QUEUE_DEPTH) c = QUEUE_DEPTH;
      return c;
   endfunction

   function automatic void return_to_pool(logic [IDX_W-1:0] slot);
      if (pool_depth < POOL_SLOTS) begin
         pool_stack[pool_depth] = slot;
         pool_depth++;
      end
   endfunction

   function automatic void ring_advance();
      if (ring_len != 0) begin
         ring_len--;
         if (ring_len == 0) ring_head = 0;
         else ring_head = (ring_head + 1) % live_capacity();
      end
   endfunction

   function automatic void ring_append(logic [IDX_W-1:0] slot);
      int unsigned tail;
      tail = ((ring_head + ring_len) % live_capacity()) % QUEUE_DEPTH;
      ring_slots[tail] = slot;
      ring_filled[tail] = 1'b1;
      ring_len++;
   endfunction

   // true when the request would read a queue entry that has never been written
   function automatic bit reads_unwritten(logic [OPCODE_W-1:0] op);
      bit reads;
      reads = ((op == ppqm_pkg::OP_PEEK || op == ppqm_pkg::OP_POP) && ring_len != 0) ||
              (op == ppqm_pkg::OP_PUSH && ring_len >= live_capacity() &&
               policy_reg == ppqm_pkg::POL_DROP_OLD && pool_depth < POOL_SLOTS);
      return reads && !ring_filled[ring_head % QUEUE_DEPTH];
   endfunction

   function automatic pool_reply_type apply_pool_op(logic [OPCODE_W-1:0] op,
                                                    logic [IDX_W-1:0] slot);
      pool_reply_type r;
      logic [IDX_W-1:0] oldest;
      r.status = ppqm_pkg::ST_OK;
      r.result_index = '0;
      r.dropped_valid = 1'b0;
      r.dropped_index = '0;
      case (op)
         ppqm_pkg::OP_ALLOC: begin
            if (pool_depth == 0) r.status = ppqm_pkg::ST_NO_FREE;
            else begin
               pool_depth--;
               r.result_index = pool_stack[pool_depth];
            end
         end
         ppqm_pkg::OP_FREE: begin
            if (pool_depth >= POOL_SLOTS) r.status = ppqm_pkg::ST_FREE_FULL;
            else return_to_pool(slot);
         end
         ppqm_pkg::OP_PUSH: begin
            if (ring_len < live_capacity()) ring_append(slot);
            else if (policy_reg != ppqm_pkg::POL_DROP_OLD &&
                     policy_reg != ppqm_pkg::POL_DROP_NEW)
               r.status = ppqm_pkg::ST_OVERFLOW;
            else if (pool_depth >= POOL_SLOTS) r.status = ppqm_pkg::ST_FREE_FULL;
            else if (policy_reg == ppqm_pkg::POL_DROP_OLD) begin
               oldest = ring_slots[ring_head % QUEUE_DEPTH];
               ring_advance();
               return_to_pool(oldest);
               ring_append(slot);
               r.dropped_valid = 1'b1;
               r.dropped_index = oldest;
            end else begin
               return_to_pool(slot);
               r.dropped_valid = 1'b1;
               r.dropped_index = slot;
            end
         end
         ppqm_pkg::OP_PEEK, ppqm_pkg::OP_POP: begin
            if (ring_len == 0) r.status = ppqm_pkg::ST_EMPTY;
            else begin
               r.result_index = ring_slots[ring_head % QUEUE_DEPTH];
               if (op == ppqm_pkg::OP_POP) ring_advance();
            end
         end
         default: ;
      endcase
      r.free_slots = COUNT_W'(pool_depth);
      r.queue_count = COUNT_W'(ring_len);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch on %s: got %0d, expected %0d (response %0d)",
                  field, got, want, replies_checked);
   endtask

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      pool_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reply_queue.size() == 0) report_mismatch("unexpected response", 1, 0);
         else begin
            want = reply_queue.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_result_index !== want.result_index)
               report_mismatch("result_index", 32'(rsp_result_index),
                               32'(want.result_index));
            if (rsp_dropped_valid !== want.dropped_valid)
               report_mismatch("dropped_valid", 32'(rsp_dropped_valid),
                               32'(want.dropped_valid));
            if (rsp_dropped_index !== want.dropped_index)
               report_mismatch("dropped_index", 32'(rsp_dropped_index),
                               32'(want.dropped_index));
            if (rsp_free_slots !== want.free_slots)
               report_mismatch("free_slots", 32'(rsp_free_slots), 32'(want.free_slots));
            if (rsp_queue_count !== want.queue_count)
               report_mismatch("queue_count", 32'(rsp_queue_count), 32'(want.queue_count));
            replies_checked++;
         end
      end
   end

   // receiver stalls: random runs, plus a long hold when one is requested
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else begin
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
            holds_done++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_percent != 0 && $urandom_range(0, 99) < idle_percent / 2) begin
            stall_left = pick_gap() - 1;
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] slot);
      int gap;
      gap = 0;
      if (reads_unwritten(op)) op = ppqm_pkg::OP_ALLOC;
      if (idle_percent != 0 && $urandom_range(0, 99) < idle_percent) gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_slot_index <= slot;
      do @(posedge clock); while (req_stall);
      last_reply = apply_pool_op(op, slot);
      reply_queue.push_back(last_reply);
      requests_sent++;
      status_tally[last_reply.status]++;
      if (last_reply.dropped_valid) dropping_pushes++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ppqm_pkg::CSR_QUEUE_CAPACITY) capacity_reg = data[CAP_W-1:0];
      else policy_reg = data[POLICY_W-1:0];
      register_writes++;
      @(posedge clock);
   endtask

   // let every outstanding request come back, then give the block time to go idle
   task automatic settle_block();
      req_valid <= 1'b0;
      while (reply_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly alloc/push and pop/free pairs, with bursts that drain the pool and some noise
   task automatic run_random_traffic(input int count, input int push_bias);
      int n;
      int kind;
      int k;
      int pick;
      logic [IDX_W-1:0] slot;
      logic [OPCODE_W-1:0] op;
      logic [IDX_W-1:0] held [$];
      n = 0;
      while (n < count) begin
         kind = $urandom_range(0, 99);
         if (kind < push_bias) begin
            send_request(ppqm_pkg::OP_ALLOC, IDX_W'($urandom_range(0, 15)));
            n++;
            if (last_reply.status == ppqm_pkg::ST_OK) begin
               send_request(ppqm_pkg::OP_PUSH, last_reply.result_index);
               n++;
            end
         end else if (kind < 78) begin
            op = ($urandom_range(0, 3) == 0) ? ppqm_pkg::OP_PEEK : ppqm_pkg::OP_POP;
            send_request(op, IDX_W'($urandom_range(0, 15)));
            n++;
            if (op == ppqm_pkg::OP_POP && last_reply.status == ppqm_pkg::ST_OK) begin
               send_request(ppqm_pkg::OP_FREE, last_reply.result_index);
               n++;
            end
         end else if (kind < 88) begin
            k = $urandom_range(1, POOL_SLOTS + 1);
            repeat (k) begin
               send_request(ppqm_pkg::OP_ALLOC, IDX_W'($urandom_range(0, 15)));
               n++;
               if (last_reply.status == ppqm_pkg::ST_OK)
                  held.push_back(last_reply.result_index);
            end
            while (held.size() != 0) begin
               pick = $urandom_range(0, held.size() - 1);
               slot = held[pick];
               held.delete(pick);
               send_request(ppqm_pkg::OP_FREE, slot);
               n++;
            end
         end else begin
            op = OPCODE_W'($urandom_range(0, 7));
            send_request(op, IDX_W'($urandom_range(0, 15)));
            if (op <= ppqm_pkg::OP_POP) n++;
         end
      end
   endtask

   task automatic test_empty_queue_and_full_pool();
      send_request(ppqm_pkg::OP_PEEK, 4'd0);
      send_request(ppqm_pkg::OP_POP, 4'd15);
      send_request(ppqm_pkg::OP_FREE, 4'd15);
      send_request(ppqm_pkg::OP_FREE, 4'd0);
   endtask

   task automatic test_unknown_opcodes();
      send_request(3'd5, 4'd15);
      send_request(3'd6, 4'd0);
      send_request(3'd7, 4'd10);
   endtask

   task automatic test_full_queue_policies();
      settle_block();
      write_register(ppqm_pkg::CSR_QUEUE_CAPACITY, 5'd0);
      write_register(ppqm_pkg::CSR_DROP_POLICY, CSR_DATA_W'(ppqm_pkg::POL_ERROR));
      send_request(ppqm_pkg::OP_ALLOC, 4'd0);
      send_request(ppqm_pkg::OP_PUSH, last_reply.result_index);
      send_request(ppqm_pkg::OP_PUSH, 4'd0);
      settle_block();
      write_register(ppqm_pkg::CSR_DROP_POLICY, CSR_DATA_W'(ppqm_pkg::POL_ERROR_ALT));
      send_request(ppqm_pkg::OP_PUSH, 4'd15);
      settle_block();
      write_register(ppqm_pkg::CSR_DROP_POLICY, CSR_DATA_W'(ppqm_pkg::POL_DROP_NEW));
      send_request(ppqm_pkg::OP_PUSH, 4'd7);
      // pool is full again, so the next dropping push cannot return a slot
      send_request(ppqm_pkg::OP_PUSH, 4'd0);
      settle_block();
      write_register(ppqm_pkg::CSR_DROP_POLICY, CSR_DATA_W'(ppqm_pkg::POL_DROP_OLD));
      send_request(ppqm_pkg::OP_PUSH, 4'd3);
      send_request(ppqm_pkg::OP_ALLOC, 4'd0);
      send_request(ppqm_pkg::OP_PUSH, 4'd9);
      send_request(ppqm_pkg::OP_PEEK, 4'd0);
      send_request(ppqm_pkg::OP_POP, 4'd0);
      send_request(ppqm_pkg::OP_FREE, 4'd9);
   endtask

   task automatic test_receiver_hold();
      settle_block();
      write_register(ppqm_pkg::CSR_QUEUE_CAPACITY, 5'd16);
      write_register(ppqm_pkg::CSR_DROP_POLICY, CSR_DATA_W'(ppqm_pkg::POL_DROP_OLD));
      idle_percent = 0;
      hold_pending = 1'b1;
      run_random_traffic(30, 60);
      settle_block();
      idle_percent = 30;
   endtask

   task automatic test_random_phases();
      logic [CAP_W-1:0] cap;
      for (int p = 0; p < 8; p++) begin
         settle_block();
         case (p)
            0, 6:    cap = 5'd16;
            1:       cap = 5'd1;
            2:       cap = 5'd0;
            3:       cap = 5'd31;
            4:       cap = 5'd17;
            5:       cap = CAP_W'($urandom_range(2, 15));
            default: cap = CAP_W'($urandom_range(0, 31));
         endcase
         // queued entries are kept across phases, so capacity changes under load too
         write_register(ppqm_pkg::CSR_QUEUE_CAPACITY, cap);
         write_register(ppqm_pkg::CSR_DROP_POLICY, {3'($urandom_range(0, 7)), 2'(p % 4)});
         idle_percent = (p == 2 || p == 5) ? 0 : 30;
         run_random_traffic(40, (p % 2 == 0) ? 55 : 35);
      end
      idle_percent = 30;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = ppqm_pkg::OP_ALLOC;
      req_slot_index = '0;
      csr_wr_en = 1'b0;
      csr_index = ppqm_pkg::CSR_QUEUE_CAPACITY;
      csr_wr_data = '0;
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue_and_full_pool();
      test_unknown_opcodes();
      test_full_queue_policies();
      test_receiver_hold();
      test_random_phases();
      settle_block();
      $display("run covered %0d requests, %0d responses checked, %0d register writes, %0d long holds",
               requests_sent, replies_checked, register_writes, holds_done);
      $display("statuses ok %0d, empty %0d, overflow %0d, no free %0d, pool full %0d",
               status_tally[ppqm_pkg::ST_OK], status_tally[ppqm_pkg::ST_EMPTY],
               status_tally[ppqm_pkg::ST_OVERFLOW], status_tally[ppqm_pkg::ST_NO_FREE],
               status_tally[ppqm_pkg::ST_FREE_FULL]);
      $display("%0d pushes handed a slot back to the pool", dropping_pushes);
      if (error_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ppqm_pkg.sv
hdl/packet_pool_and_queue_manager_unit.sv
tb/tb_packet_pool_and_queue_manager_unit.sv
